// File: rtl/dpf_pkg.sv
package dpf_pkg;

  localparam int unsigned ENTRIES = 32;
  localparam int unsigned IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned SLOT_W  = 5;
  localparam int unsigned STAMP_W = 32;
  localparam int unsigned ADDR_W  = 3;
  localparam int unsigned DATA_W  = 32;

  typedef logic [IDX_W-1:0] idx_t;

  localparam idx_t LAST_IDX = idx_t'(ENTRIES - 1);

  localparam logic [STAMP_W-1:0] TIMEOUT_RESET = 32'd30000;
  localparam logic [STAMP_W-1:0] STAMP_MAX     = 32'hFFFF_FFFF;

  localparam logic CMD_CHECK = 1'b0;
  localparam logic CMD_PRUNE = 1'b1;

  // Register index taken from paddr[ADDR_W-1:2]
  localparam logic [ADDR_W-3:0] REG_TIMEOUT = '0;

  typedef struct packed {
    logic               cmd;
    logic [7:0]         orig_id;
    logic [15:0]        seq_num;
    logic [STAMP_W-1:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic              is_duplicate;
    logic [SLOT_W-1:0] slot;
  } out_item_t;

  typedef struct packed {
    logic [7:0]         origin;
    logic [15:0]        seq;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_TAIL,
    ST_DONE
  } state_e;

  function automatic logic [SLOT_W-1:0] to_slot(input idx_t idx);
    return SLOT_W'(idx);
  endfunction

endpackage

// File: rtl/dpf_mem.sv
module dpf_mem (
  input  logic            clk_i,
  input  logic            we_i,
  input  dpf_pkg::idx_t   waddr_i,
  input  dpf_pkg::entry_t wdata_i,
  input  logic            re_i,
  input  dpf_pkg::idx_t   raddr_i,
  output dpf_pkg::entry_t rdata_o
);

  dpf_pkg::entry_t mem_q [dpf_pkg::ENTRIES];
  dpf_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/duplicate_packet_filter.sv
// Channel   Direction  Handshake               Payload
// in        input      in_valid_i / in_ready_o   in_item_i  (cmd, orig_id, seq_num, now_ms)
// out       output     out_valid_o / out_ready_i out_item_o (is_duplicate, slot)
// cfg       input      APB psel/penable/pwrite   timeout register at byte address 0
//
// An item is accepted, then one entry is read per cycle from the entry memory (separate
// read and write ports), the last read is evaluated, and finally the new entry is
// written and the output register loaded.
// A result waits in the output register; the next item is taken meanwhile, but the
// write-back cycle holds until the output register is free.
// Reset clears the used map and the timeout goes to 30000 ms; no clearing pass.
module duplicate_packet_filter (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  dpf_pkg::in_item_t              in_item_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output dpf_pkg::out_item_t             out_item_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [dpf_pkg::ADDR_W-1:0]     paddr,
  input  logic [dpf_pkg::DATA_W-1:0]     pwdata,
  output logic [dpf_pkg::DATA_W-1:0]     prdata,
  output logic                           pready
);

  dpf_pkg::state_e state_q, state_d;

  logic [dpf_pkg::STAMP_W-1:0] timeout_q;
  logic                        reg_sel;

  dpf_pkg::in_item_t item_q;
  dpf_pkg::idx_t     cnt_q, cnt_d;
  dpf_pkg::idx_t     ev_idx_q;
  logic              ev_vld_q;

  logic [dpf_pkg::ENTRIES-1:0] used_q, used_d;

  logic                        hit_q, hit_d;
  dpf_pkg::idx_t               hit_idx_q, hit_idx_d;
  logic                        free_q, free_d;
  dpf_pkg::idx_t               free_idx_q, free_idx_d;
  logic [dpf_pkg::STAMP_W-1:0] min_stamp_q, min_stamp_d;
  dpf_pkg::idx_t               min_idx_q, min_idx_d;

  logic                        out_valid_q;
  dpf_pkg::out_item_t          out_item_q;

  logic                        accept;
  logic                        rd_en;
  logic                        fire;
  logic                        do_write;
  dpf_pkg::idx_t               victim;
  dpf_pkg::entry_t             rd_data;
  dpf_pkg::entry_t             wr_data;
  logic [dpf_pkg::STAMP_W-1:0] age;
  logic                        ev_used;

  // Configuration port
  assign pready  = 1'b1;
  assign reg_sel = (paddr[dpf_pkg::ADDR_W-1:2] == dpf_pkg::REG_TIMEOUT);
  assign prdata  = reg_sel ? timeout_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= dpf_pkg::TIMEOUT_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      timeout_q <= pwdata;
    end
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dpf_pkg::ST_IDLE: if (in_valid_i) state_d = dpf_pkg::ST_SCAN;
      dpf_pkg::ST_SCAN: if (cnt_q == dpf_pkg::LAST_IDX) state_d = dpf_pkg::ST_TAIL;
      dpf_pkg::ST_TAIL: state_d = dpf_pkg::ST_DONE;
      dpf_pkg::ST_DONE: if (!out_valid_q || out_ready_i) state_d = dpf_pkg::ST_IDLE;
      default:          state_d = dpf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    rd_en      = 1'b0;
    fire       = 1'b0;
    unique case (state_q)
      dpf_pkg::ST_IDLE: in_ready_o = 1'b1;
      dpf_pkg::ST_SCAN: rd_en = 1'b1;
      dpf_pkg::ST_TAIL: ;
      dpf_pkg::ST_DONE: fire = !out_valid_q || out_ready_i;
      default:          ;
    endcase
  end

  assign accept = in_valid_i && in_ready_o;
  assign cnt_d  = (state_q == dpf_pkg::ST_SCAN) ? cnt_q + 1'b1 : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= dpf_pkg::ST_IDLE;
      cnt_q    <= '0;
      ev_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      ev_vld_q <= rd_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_item_i;
    end
    if (rd_en) begin
      ev_idx_q <= cnt_q;
    end
  end

  dpf_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (do_write),
    .waddr_i (victim),
    .wdata_i (wr_data),
    .re_i    (rd_en),
    .raddr_i (cnt_q),
    .rdata_o (rd_data)
  );

  // Shared evaluation of one entry per cycle: match, free slot, oldest stamp, age
  assign ev_used = used_q[ev_idx_q];
  assign age     = item_q.now_ms - rd_data.stamp;

  always_comb begin
    hit_d       = hit_q;
    hit_idx_d   = hit_idx_q;
    free_d      = free_q;
    free_idx_d  = free_idx_q;
    min_stamp_d = min_stamp_q;
    min_idx_d   = min_idx_q;
    used_d      = used_q;
    if (accept) begin
      hit_d       = 1'b0;
      free_d      = 1'b0;
      min_stamp_d = dpf_pkg::STAMP_MAX;
      min_idx_d   = '0;
    end else if (ev_vld_q) begin
      if (item_q.cmd == dpf_pkg::CMD_PRUNE) begin
        // drop entries older than the timeout
        if (ev_used && (age > timeout_q)) begin
          used_d[ev_idx_q] = 1'b0;
        end
      end else begin
        if (ev_used && !hit_q && rd_data.origin == item_q.orig_id
            && rd_data.seq == item_q.seq_num) begin
          hit_d     = 1'b1;
          hit_idx_d = ev_idx_q;
        end
        if (!ev_used && !free_q) begin
          free_d     = 1'b1;
          free_idx_d = ev_idx_q;
        end
        // strict compare keeps the first minimum
        if (ev_used && (rd_data.stamp < min_stamp_q)) begin
          min_stamp_d = rd_data.stamp;
          min_idx_d   = ev_idx_q;
        end
      end
    end else if (do_write) begin
      used_d[victim] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else begin
      used_q <= used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_q       <= hit_d;
    hit_idx_q   <= hit_idx_d;
    free_q      <= free_d;
    free_idx_q  <= free_idx_d;
    min_stamp_q <= min_stamp_d;
    min_idx_q   <= min_idx_d;
  end

  // Write-back and result
  assign victim   = free_q ? free_idx_q : min_idx_q;
  assign do_write = fire && (item_q.cmd == dpf_pkg::CMD_CHECK) && !hit_q;
  assign wr_data  = '{origin: item_q.orig_id, seq: item_q.seq_num,
                      stamp: item_q.now_ms};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      if (item_q.cmd == dpf_pkg::CMD_PRUNE) begin
        out_item_q <= '0;
      end else begin
        out_item_q.is_duplicate <= hit_q;
        out_item_q.slot         <= dpf_pkg::to_slot(hit_q ? hit_idx_q : victim);
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // Assertions
  a_accept_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == dpf_pkg::ST_SCAN))
    else $error("accepted item did not start a scan");

  a_eval_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_vld_q |-> (state_q == dpf_pkg::ST_SCAN || state_q == dpf_pkg::ST_TAIL))
    else $error("entry evaluated outside of scan");

  a_scan_never_sets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dpf_pkg::ST_SCAN || state_q == dpf_pkg::ST_TAIL)
    |=> ($countones(used_q) <= $past($countones(used_q))))
    else $error("used map grew during a scan");

  a_write_marks_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_write |=> used_q[$past(victim)])
    else $error("recorded entry not marked used");

  a_hit_reports_dup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && item_q.cmd == dpf_pkg::CMD_CHECK && hit_q)
    |=> (out_valid_o && out_item_o.is_duplicate))
    else $error("hit not reported as duplicate");

endmodule

// File: verif/duplicate_packet_filter_test.sv
`timescale 1ns / 1ps

module duplicate_packet_filter_test;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned PHASE_ITEMS = 290;
  localparam logic [dpf_pkg::ADDR_W-3:0] REG_SPARE = 1'b1;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  dpf_pkg::in_item_t in_item_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  dpf_pkg::out_item_t out_item_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [dpf_pkg::ADDR_W-1:0] paddr = '0;
  logic [dpf_pkg::DATA_W-1:0] pwdata = '0;
  logic [dpf_pkg::DATA_W-1:0] prdata;
  logic pready;

  duplicate_packet_filter u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // Predicted table contents
  logic        seen_used   [dpf_pkg::ENTRIES];
  logic [7:0]  seen_origin [dpf_pkg::ENTRIES];
  logic [15:0] seen_seq    [dpf_pkg::ENTRIES];
  logic [31:0] seen_stamp  [dpf_pkg::ENTRIES];
  logic [31:0] timeout_ms = dpf_pkg::TIMEOUT_RESET;

  dpf_pkg::in_item_t  pending_packets[$];
  dpf_pkg::out_item_t expected_verdicts[$];
  dpf_pkg::out_item_t oldest_verdict;
  logic [23:0] recent_pairs[$];

  int unsigned queued_total = 0;
  int unsigned verdicts_seen = 0;
  int unsigned mismatch_count = 0;
  int unsigned stall_cycles = 0;
  int unsigned in_gap_left = 0;
  int unsigned out_stall_left = 0;
  logic        item_taken = 1'b0;
  bit          steady_in = 1'b0;
  bit          steady_out = 1'b0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic dpf_pkg::out_item_t screen_packet(dpf_pkg::in_item_t pkt);
    dpf_pkg::out_item_t verdict;
    int hit;
    int victim;
    int best;
    logic [31:0] oldest;
    logic [31:0] age;
    verdict = '0;
    if (pkt.cmd == dpf_pkg::CMD_PRUNE) begin
      for (int i = 0; i < dpf_pkg::ENTRIES; i++) begin
        age = pkt.now_ms - seen_stamp[i];
        if (seen_used[i] && age > timeout_ms) seen_used[i] = 1'b0;
      end
      return verdict;
    end
    hit = -1;
    for (int i = 0; i < dpf_pkg::ENTRIES; i++) begin
      if (hit < 0 && seen_used[i] && seen_origin[i] == pkt.orig_id &&
          seen_seq[i] == pkt.seq_num) hit = i;
    end
    if (hit >= 0) begin
      verdict.is_duplicate = 1'b1;
      verdict.slot = hit[dpf_pkg::SLOT_W-1:0];
      return verdict;
    end
    // first free entry, else the lowest raw stamp (lowest index on ties)
    victim = -1;
    best = 0;
    oldest = dpf_pkg::STAMP_MAX;
    for (int i = 0; i < dpf_pkg::ENTRIES; i++) begin
      if (victim < 0) begin
        if (!seen_used[i]) begin
          victim = i;
        end else if (seen_stamp[i] < oldest) begin
          oldest = seen_stamp[i];
          best = i;
        end
      end
    end
    if (victim < 0) victim = best;
    seen_used[victim] = 1'b1;
    seen_origin[victim] = pkt.orig_id;
    seen_seq[victim] = pkt.seq_num;
    seen_stamp[victim] = pkt.now_ms;
    verdict.slot = victim[dpf_pkg::SLOT_W-1:0];
    return verdict;
  endfunction

  function automatic int unsigned pick_gap(bit steady);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (steady || roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic log_mismatch(input string what, input logic [31:0] got,
                              input logic [31:0] want);
    if (mismatch_count < 50)
      $display("%0t %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic queue_packet(input logic cmd, input logic [7:0] orig,
                              input logic [15:0] seq, input logic [31:0] now);
    dpf_pkg::in_item_t pkt;
    pkt.cmd = cmd;
    pkt.orig_id = orig;
    pkt.seq_num = seq;
    pkt.now_ms = now;
    pending_packets.push_back(pkt);
    queued_total++;
  endtask

  task automatic wait_for_drain();
    while (verdicts_seen != queued_total) @(negedge clk_i);
  endtask

  task automatic apb_write(input logic [dpf_pkg::ADDR_W-3:0] index,
                           input logic [31:0] value);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {index, 2'b00};
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (index == dpf_pkg::REG_TIMEOUT) timeout_ms = value;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic apb_check_read(input logic [dpf_pkg::ADDR_W-3:0] index,
                                input logic [31:0] want);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {index, 2'b00};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== want) log_mismatch("timeout readback", prdata, want);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Input driver: hold the item until taken, then idle or advance
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || item_taken) begin
      if (in_gap_left != 0) begin
        in_valid_i <= 1'b0;
        in_gap_left <= in_gap_left - 1;
      end else if (pending_packets.size() != 0) begin
        in_valid_i <= 1'b1;
        in_item_i <= pending_packets.pop_front();
        in_gap_left <= pick_gap(steady_in);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (out_stall_left != 0) begin
      out_ready_i <= 1'b0;
      out_stall_left <= out_stall_left - 1;
    end else begin
      out_ready_i <= 1'b1;
      out_stall_left <= pick_gap(steady_out);
    end
  end

  always @(posedge clk_i) begin
    item_taken <= rst_ni && in_valid_i && in_ready_o;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        verdicts_seen <= verdicts_seen + 1;
        if (expected_verdicts.size() == 0) begin
          log_mismatch("result with no item pending", {26'b0, out_item_o}, '0);
        end else begin
          oldest_verdict = expected_verdicts.pop_front();
          if (out_item_o.is_duplicate !== oldest_verdict.is_duplicate)
            log_mismatch("is_duplicate", 32'(out_item_o.is_duplicate),
                         32'(oldest_verdict.is_duplicate));
          if (out_item_o.slot !== oldest_verdict.slot)
            log_mismatch("slot", 32'(out_item_o.slot), 32'(oldest_verdict.slot));
        end
      end
      if (in_valid_i && in_ready_o) expected_verdicts.push_back(screen_packet(in_item_i));
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (psel && penable && pready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("duplicate_packet_filter: mismatch");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    logic [31:0] timeouts [6];
    logic [31:0] step_max;
    logic [31:0] clock_ms;
    logic [23:0] pair;
    int unsigned roll;

    for (int i = 0; i < dpf_pkg::ENTRIES; i++) begin
      seen_used[i] = 1'b0;
      seen_origin[i] = '0;
      seen_seq[i] = '0;
      seen_stamp[i] = '0;
    end
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    queue_packet(dpf_pkg::CMD_CHECK, 8'h00, 16'h0000, 32'd0);
    queue_packet(dpf_pkg::CMD_CHECK, 8'hFF, 16'hFFFF, dpf_pkg::STAMP_MAX);
    queue_packet(dpf_pkg::CMD_CHECK, 8'h00, 16'h0000, 32'd5);
    queue_packet(dpf_pkg::CMD_CHECK, 8'h00, 16'hFFFF, 32'd1);
    queue_packet(dpf_pkg::CMD_CHECK, 8'hFF, 16'h0000, 32'd2);
    // a hit does not care about the age of the entry
    queue_packet(dpf_pkg::CMD_CHECK, 8'hFF, 16'hFFFF, 32'd100000);
    // drop entries older than 30000, keep the one exactly at the timeout
    queue_packet(dpf_pkg::CMD_PRUNE, 8'hAA, 16'h5555, 32'd30001);
    queue_packet(dpf_pkg::CMD_CHECK, 8'h00, 16'h0000, 32'd30002);
    queue_packet(dpf_pkg::CMD_CHECK, 8'h00, 16'hFFFF, 32'd30003);
    queue_packet(dpf_pkg::CMD_PRUNE, 8'hFF, 16'hFFFF, 32'd30003);
    queue_packet(dpf_pkg::CMD_CHECK, 8'hFF, 16'h0000, 32'd30004);
    queue_packet(dpf_pkg::CMD_CHECK, 8'h00, 16'h0000, 32'd30005);
    wait_for_drain();
    // a write to a register that does not exist must leave the timeout alone
    apb_write(REG_SPARE, 32'h1234_5678);
    apb_check_read(dpf_pkg::REG_TIMEOUT, dpf_pkg::TIMEOUT_RESET);

    timeouts[0] = dpf_pkg::TIMEOUT_RESET;
    timeouts[1] = dpf_pkg::STAMP_MAX;
    timeouts[2] = 32'd0;
    timeouts[3] = 32'd1000;
    timeouts[4] = $urandom;
    timeouts[5] = 32'd20;
    for (int p = 0; p < 6; p++) begin
      if (p != 0) begin
        apb_write(dpf_pkg::REG_TIMEOUT, timeouts[p]);
        apb_check_read(dpf_pkg::REG_TIMEOUT, timeouts[p]);
      end
      steady_in = ($urandom_range(0, 3) == 0);
      steady_out = ($urandom_range(0, 3) == 0);
      step_max = (timeouts[p] > 32'h1000_0000) ? 32'h1000_0000 : timeouts[p] / 6 + 3;
      clock_ms = $urandom;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // repeat the time now and then so equal stamps compete for eviction
        if ($urandom_range(0, 4) != 0) clock_ms += $urandom_range(1, step_max);
        roll = $urandom_range(0, 99);
        if (roll < 55 && recent_pairs.size() != 0) begin
          pair = recent_pairs[$urandom_range(0, recent_pairs.size() - 1)];
          queue_packet(dpf_pkg::CMD_CHECK, pair[23:16], pair[15:0], clock_ms);
        end else if (roll < 85) begin
          pair = 24'($urandom);
          recent_pairs.push_back(pair);
          if (recent_pairs.size() > 40) void'(recent_pairs.pop_front());
          queue_packet(dpf_pkg::CMD_CHECK, pair[23:16], pair[15:0], clock_ms);
        end else if (roll < 95) begin
          queue_packet(dpf_pkg::CMD_PRUNE, 8'($urandom), 16'($urandom), clock_ms);
        end else begin
          queue_packet($urandom_range(0, 1) ? dpf_pkg::CMD_PRUNE : dpf_pkg::CMD_CHECK,
                       8'($urandom), 16'($urandom), $urandom);
        end
      end
      wait_for_drain();
    end

    repeat (40) @(posedge clk_i);
    if (expected_verdicts.size() != 0)
      log_mismatch("results never delivered", expected_verdicts.size(), '0);
    if (mismatch_count == 0) begin
      $display("duplicate_packet_filter: match");
    end else begin
      $display("duplicate_packet_filter: mismatch");
    end
    $finish;
  end

endmodule
